FILE: rtl/hpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg
// Types, constants and the arctangent table for the path length block.
// ----------------------------------------------------------------------------
package hpl_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int SUM_BITS_DEF     = 40;

  localparam int RADIUS_W = 23;
  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int LEN_W    = 40;
  localparam int R100_W   = 30;

  localparam int ANG_W = 36;
  localparam int XY_W  = 35;
  localparam int VAL_W = 34;
  localparam int MUL_W = 34;
  localparam int PRD_W = 68;
  localparam int H_W   = 31;
  localparam int SQ_W  = 64;
  localparam int SEG_W = 32;

  localparam logic [R100_W-1:0] RADIUS100_RESET = 30'd637100000;

  localparam logic signed [ANG_W-1:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [XY_W-1:0]  GAIN_Q    = 35'sd652032874;
  localparam logic signed [MUL_W-1:0] DEG_TO_RAD = 34'sd4024455254;
  localparam logic [H_W-1:0]          Q_ONE     = 31'h4000_0000;
  localparam logic [SQ_W-1:0]         SQ_BIT_TOP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat_e7;
    logic signed [LON_W-1:0] lon_e7;
    logic                    last_point;
  } hpl_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] length_cm;
    logic             saturated;
  } hpl_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RAD0, ST_RAD1, ST_RAD2, ST_RAD3, ST_RAD4,
    ST_SC_LD, ST_SC_PREP, ST_SC_RUN, ST_SC_WB,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_H,
    ST_SQ_LD, ST_SQ_RUN, ST_SQ_WB,
    ST_AT_LD, ST_AT_RUN, ST_AT_WB,
    ST_SEG0, ST_SEG1, ST_ACC, ST_UPD
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_PLAT, MUL_PLON, MUL_CLAT, MUL_CLON,
    MUL_C1C2, MUL_SLSL, MUL_SPSP, MUL_T1T2, MUL_RANG
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_P1, WB_L1, WB_P2, WB_L2,
    WB_T1, WB_T2, WB_T3, WB_T4, WB_SEG
  } wb_t;

  typedef struct packed {
    logic       accept;
    mul_op_t    mul;
    wb_t        wb;
    logic       sc_load;
    logic       sc_prep;
    logic       at_load;
    logic       cordic_run;
    logic       sc_wb;
    logic       at_wb;
    logic       h_load;
    logic       sq_load;
    logic       sq_run;
    logic       sq_wb;
    logic       acc;
    logic       upd;
    logic       emit;
    logic [1:0] sel;
  } hpl_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic cordic_last;
    logic sqrt_last;
    logic can_emit;
  } hpl_sts_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ctrl
// Sequencer: steps the datapath through one segment and the final update.
// ----------------------------------------------------------------------------
module hpl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  hpl_pkg::hpl_sts_t      sts,
  output hpl_pkg::hpl_cmd_t      cmd
);

  hpl_pkg::state_t state, state_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpl_pkg::ST_IDLE;
      sel   <= 2'd0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.mul    = hpl_pkg::MUL_NONE;
    cmd.wb     = hpl_pkg::WB_NONE;
    cmd.sel    = sel;
    in_stall   = (state != hpl_pkg::ST_IDLE);
    case (state)
      hpl_pkg::ST_IDLE: begin
        sel_next = 2'd0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.have_prev ? hpl_pkg::ST_RAD0 : hpl_pkg::ST_UPD;
        end
      end
      hpl_pkg::ST_RAD0: begin
        cmd.mul = hpl_pkg::MUL_PLAT;
        state_next = hpl_pkg::ST_RAD1;
      end
      hpl_pkg::ST_RAD1: begin
        cmd.mul = hpl_pkg::MUL_PLON;
        cmd.wb  = hpl_pkg::WB_P1;
        state_next = hpl_pkg::ST_RAD2;
      end
      hpl_pkg::ST_RAD2: begin
        cmd.mul = hpl_pkg::MUL_CLAT;
        cmd.wb  = hpl_pkg::WB_L1;
        state_next = hpl_pkg::ST_RAD3;
      end
      hpl_pkg::ST_RAD3: begin
        cmd.mul = hpl_pkg::MUL_CLON;
        cmd.wb  = hpl_pkg::WB_P2;
        state_next = hpl_pkg::ST_RAD4;
      end
      hpl_pkg::ST_RAD4: begin
        cmd.wb = hpl_pkg::WB_L2;
        state_next = hpl_pkg::ST_SC_LD;
      end
      hpl_pkg::ST_SC_LD: begin
        cmd.sc_load = 1'b1;
        state_next = hpl_pkg::ST_SC_PREP;
      end
      hpl_pkg::ST_SC_PREP: begin
        cmd.sc_prep = 1'b1;
        state_next = hpl_pkg::ST_SC_RUN;
      end
      hpl_pkg::ST_SC_RUN: begin
        cmd.cordic_run = 1'b1;
        if (sts.cordic_last) begin
          state_next = hpl_pkg::ST_SC_WB;
        end
      end
      hpl_pkg::ST_SC_WB: begin
        cmd.sc_wb = 1'b1;
        sel_next = sel + 2'd1;
        state_next = (sel == 2'd3) ? hpl_pkg::ST_M0 : hpl_pkg::ST_SC_LD;
      end
      hpl_pkg::ST_M0: begin
        cmd.mul = hpl_pkg::MUL_C1C2;
        state_next = hpl_pkg::ST_M1;
      end
      hpl_pkg::ST_M1: begin
        cmd.mul = hpl_pkg::MUL_SLSL;
        cmd.wb  = hpl_pkg::WB_T1;
        state_next = hpl_pkg::ST_M2;
      end
      hpl_pkg::ST_M2: begin
        cmd.mul = hpl_pkg::MUL_SPSP;
        cmd.wb  = hpl_pkg::WB_T2;
        state_next = hpl_pkg::ST_M3;
      end
      hpl_pkg::ST_M3: begin
        cmd.mul = hpl_pkg::MUL_T1T2;
        cmd.wb  = hpl_pkg::WB_T4;
        state_next = hpl_pkg::ST_M4;
      end
      hpl_pkg::ST_M4: begin
        cmd.wb = hpl_pkg::WB_T3;
        state_next = hpl_pkg::ST_H;
      end
      hpl_pkg::ST_H: begin
        cmd.h_load = 1'b1;
        sel_next = 2'd0;
        state_next = hpl_pkg::ST_SQ_LD;
      end
      hpl_pkg::ST_SQ_LD: begin
        cmd.sq_load = 1'b1;
        state_next = hpl_pkg::ST_SQ_RUN;
      end
      hpl_pkg::ST_SQ_RUN: begin
        cmd.sq_run = 1'b1;
        if (sts.sqrt_last) begin
          state_next = hpl_pkg::ST_SQ_WB;
        end
      end
      hpl_pkg::ST_SQ_WB: begin
        cmd.sq_wb = 1'b1;
        sel_next = sel + 2'd1;
        state_next = (sel == 2'd1) ? hpl_pkg::ST_AT_LD : hpl_pkg::ST_SQ_LD;
      end
      hpl_pkg::ST_AT_LD: begin
        cmd.at_load = 1'b1;
        state_next = hpl_pkg::ST_AT_RUN;
      end
      hpl_pkg::ST_AT_RUN: begin
        cmd.cordic_run = 1'b1;
        if (sts.cordic_last) begin
          state_next = hpl_pkg::ST_AT_WB;
        end
      end
      hpl_pkg::ST_AT_WB: begin
        cmd.at_wb = 1'b1;
        state_next = hpl_pkg::ST_SEG0;
      end
      hpl_pkg::ST_SEG0: begin
        cmd.mul = hpl_pkg::MUL_RANG;
        state_next = hpl_pkg::ST_SEG1;
      end
      hpl_pkg::ST_SEG1: begin
        cmd.wb = hpl_pkg::WB_SEG;
        state_next = hpl_pkg::ST_ACC;
      end
      hpl_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = hpl_pkg::ST_UPD;
      end
      hpl_pkg::ST_UPD: begin
        // on the last point, hold until the output register is free
        if (!sts.last || sts.can_emit) begin
          cmd.upd  = 1'b1;
          cmd.emit = sts.last;
          state_next = hpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hpl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/hpl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_dp
// Datapath: shared multiplier, shared CORDIC, bit-pair square root,
// saturating accumulator, point registers and output register.
// ----------------------------------------------------------------------------
module hpl_dp #(
  parameter int CORDIC_STEPS = hpl_pkg::CORDIC_STEPS_DEF,
  parameter int SUM_BITS     = hpl_pkg::SUM_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  hpl_pkg::hpl_cmd_t                  cmd,
  output hpl_pkg::hpl_sts_t                  sts,
  input  hpl_pkg::hpl_in_t                   in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hpl_pkg::hpl_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [hpl_pkg::RADIUS_W-1:0]  cfg_data
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  logic [hpl_pkg::R100_W-1:0] radius100;

  logic signed [hpl_pkg::LAT_W-1:0] cur_lat, prev_lat;
  logic signed [hpl_pkg::LON_W-1:0] cur_lon, prev_lon;
  logic cur_last, have_prev;

  logic signed [hpl_pkg::ANG_W-1:0] p1, p2, l1, l2;
  logic signed [hpl_pkg::VAL_W-1:0] sp, sl, c1, c2, t1, t2, t3, t4;
  logic [hpl_pkg::H_W-1:0] h, vx, vy;
  logic [32:0] ang;
  logic [hpl_pkg::SEG_W-1:0] seg;
  logic [SUM_BITS-1:0] sum;
  logic sat;

  logic signed [hpl_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [hpl_pkg::PRD_W-1:0] prod, prod_rnd;

  logic signed [hpl_pkg::XY_W-1:0]  cx, cy, dx, dy, cos_val;
  logic signed [hpl_pkg::ANG_W-1:0] cz, arg, at, wrapped;
  logic [IW-1:0] ci;
  logic flip, rot_mode, dir;

  logic [hpl_pkg::SQ_W-1:0] sq_n, sq_res, sq_bit, sq_sum;
  logic [hpl_pkg::H_W-1:0]  sq_v;
  logic signed [hpl_pkg::VAL_W:0] h_sum;

  logic [SUM_BITS-1:0] rem, d_ext;
  logic can_emit;

  assign can_emit = !out_valid || !out_stall;

  always_comb begin
    sts.have_prev   = have_prev;
    sts.last        = cur_last;
    sts.cordic_last = (ci == IW'(CORDIC_STEPS - 1));
    sts.sqrt_last   = sq_bit[0];
    sts.can_emit    = can_emit;
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      hpl_pkg::MUL_PLAT: begin
        mul_a = hpl_pkg::MUL_W'(prev_lat);
        mul_b = hpl_pkg::DEG_TO_RAD;
      end
      hpl_pkg::MUL_PLON: begin
        mul_a = hpl_pkg::MUL_W'(prev_lon);
        mul_b = hpl_pkg::DEG_TO_RAD;
      end
      hpl_pkg::MUL_CLAT: begin
        mul_a = hpl_pkg::MUL_W'(cur_lat);
        mul_b = hpl_pkg::DEG_TO_RAD;
      end
      hpl_pkg::MUL_CLON: begin
        mul_a = hpl_pkg::MUL_W'(cur_lon);
        mul_b = hpl_pkg::DEG_TO_RAD;
      end
      hpl_pkg::MUL_C1C2: begin
        mul_a = c1;
        mul_b = c2;
      end
      hpl_pkg::MUL_SLSL: begin
        mul_a = sl;
        mul_b = sl;
      end
      hpl_pkg::MUL_SPSP: begin
        mul_a = sp;
        mul_b = sp;
      end
      hpl_pkg::MUL_T1T2: begin
        mul_a = t1;
        mul_b = t2;
      end
      hpl_pkg::MUL_RANG: begin
        mul_a = signed'({4'b0, radius100});
        mul_b = signed'({1'b0, ang});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_rnd = prod + 68'sd536870912;

  // CORDIC argument, range reduction and step
  always_comb begin
    case (cmd.sel)
      2'd0:    arg = (p2 - p1) >>> 1;
      2'd1:    arg = (l2 - l1) >>> 1;
      2'd2:    arg = p1;
      default: arg = p2;
    endcase
  end

  always_comb begin
    if (cz > hpl_pkg::PI_Q) begin
      wrapped = cz - hpl_pkg::TWO_PI_Q;
    end else if (cz < -hpl_pkg::PI_Q) begin
      wrapped = cz + hpl_pkg::TWO_PI_Q;
    end else begin
      wrapped = cz;
    end
  end

  assign dir     = rot_mode ? !cz[hpl_pkg::ANG_W-1] : cy[hpl_pkg::XY_W-1];
  assign dx      = cy >>> ci;
  assign dy      = cx >>> ci;
  assign at      = signed'({6'b0, hpl_pkg::atan_q30(5'(ci))});
  assign cos_val = flip ? -cx : cx;

  assign sq_v   = cmd.sel[0] ? (hpl_pkg::Q_ONE - h) : h;
  assign sq_sum = sq_res + sq_bit;
  assign h_sum  = (hpl_pkg::VAL_W + 1)'(t3) + (hpl_pkg::VAL_W + 1)'(t4);

  assign rem   = SUM_MAX - sum;
  assign d_ext = SUM_BITS'(seg);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (cmd.accept) begin
      cur_lat  <= in_data.lat_e7;
      cur_lon  <= in_data.lon_e7;
      cur_last <= in_data.last_point;
    end

    case (cmd.wb)
      hpl_pkg::WB_P1:  p1  <= prod[66:31];
      hpl_pkg::WB_L1:  l1  <= prod[66:31];
      hpl_pkg::WB_P2:  p2  <= prod[66:31];
      hpl_pkg::WB_L2:  l2  <= prod[66:31];
      hpl_pkg::WB_T1:  t1  <= prod[63:30];
      hpl_pkg::WB_T2:  t2  <= prod[63:30];
      hpl_pkg::WB_T3:  t3  <= prod[63:30];
      hpl_pkg::WB_T4:  t4  <= prod[63:30];
      hpl_pkg::WB_SEG: seg <= prod_rnd[61:30];
      default: begin
      end
    endcase

    if (cmd.sc_load) begin
      cz <= arg;
      cx <= hpl_pkg::GAIN_Q;
      cy <= '0;
      ci <= '0;
      flip <= 1'b0;
      rot_mode <= 1'b1;
    end else if (cmd.at_load) begin
      cz <= '0;
      cx <= signed'({4'b0, vx});
      cy <= signed'({4'b0, vy});
      ci <= '0;
      rot_mode <= 1'b0;
    end else if (cmd.sc_prep) begin
      // fold into the right half-plane
      if (wrapped > hpl_pkg::HALF_PI_Q) begin
        cz <= hpl_pkg::PI_Q - wrapped;
        flip <= 1'b1;
      end else if (wrapped < -hpl_pkg::HALF_PI_Q) begin
        cz <= -hpl_pkg::PI_Q - wrapped;
        flip <= 1'b1;
      end else begin
        cz <= wrapped;
      end
    end else if (cmd.cordic_run) begin
      if (dir) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
      ci <= ci + 1'b1;
    end

    if (cmd.sc_wb) begin
      case (cmd.sel)
        2'd0:    sp <= cy[hpl_pkg::VAL_W-1:0];
        2'd1:    sl <= cy[hpl_pkg::VAL_W-1:0];
        2'd2:    c1 <= cos_val[hpl_pkg::VAL_W-1:0];
        default: c2 <= cos_val[hpl_pkg::VAL_W-1:0];
      endcase
    end

    if (cmd.at_wb) begin
      ang <= cz[hpl_pkg::ANG_W-1] ? 33'd0 : {cz[31:0], 1'b0};
    end

    if (cmd.h_load) begin
      if (h_sum[hpl_pkg::VAL_W]) begin
        h <= '0;
      end else if (h_sum > (hpl_pkg::VAL_W + 1)'(hpl_pkg::Q_ONE)) begin
        h <= hpl_pkg::Q_ONE;
      end else begin
        h <= h_sum[hpl_pkg::H_W-1:0];
      end
    end

    if (cmd.sq_load) begin
      sq_n   <= {3'b0, sq_v, 30'b0};
      sq_res <= '0;
      sq_bit <= hpl_pkg::SQ_BIT_TOP;
    end else if (cmd.sq_run) begin
      if (sq_n >= sq_sum) begin
        sq_n   <= sq_n - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end

    if (cmd.sq_wb) begin
      if (cmd.sel[0]) begin
        vx <= sq_res[hpl_pkg::H_W-1:0];
      end else begin
        vy <= sq_res[hpl_pkg::H_W-1:0];
      end
    end

    if (cmd.upd) begin
      prev_lat <= cur_lat;
      prev_lon <= cur_lon;
    end

    if (cmd.emit) begin
      out_data.length_cm <= hpl_pkg::LEN_W'(sum);
      out_data.saturated <= sat;
    end

    if (rst) begin
      radius100 <= hpl_pkg::RADIUS100_RESET;
      have_prev <= 1'b0;
      sum       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius100 <= hpl_pkg::R100_W'(cfg_data) * 30'd100;
      end
      if (cmd.acc) begin
        if (d_ext >= rem) begin
          if (d_ext > rem || seg != '0) begin
            sat <= 1'b1;
          end
          sum <= SUM_MAX;
        end else begin
          sum <= sum + d_ext;
        end
      end
      if (cmd.upd) begin
        if (cmd.emit) begin
          have_prev <= 1'b0;
          sum       <= '0;
          sat       <= 1'b0;
        end else begin
          have_prev <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/haversine_path_length_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_path_length_top
// Great-circle path length accumulator over a stream of points.
// ----------------------------------------------------------------------------
// Each later point of a path takes four sine/cosine and one atan2 run on the
// shared CORDIC plus two 32-step square roots; the first point of a path
// skips them. One point at a time. The result is loaded into the output
// register at the last point's update, held off while that is stalled.
// Synchronous reset clears the path state and loads the default radius.
module haversine_path_length_top #(
  parameter int CORDIC_STEPS = hpl_pkg::CORDIC_STEPS_DEF,
  parameter int SUM_BITS     = hpl_pkg::SUM_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  hpl_pkg::hpl_in_t                   in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hpl_pkg::hpl_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [hpl_pkg::RADIUS_W-1:0]  cfg_data
);

  hpl_pkg::hpl_cmd_t cmd;
  hpl_pkg::hpl_sts_t sts;

  hpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpl_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SUM_BITS     (SUM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
